>>> design/modular_exponentiation_macros.svh
// Assertion macros used by the modular exponentiation checker.
// No dependencies; include by bare file name.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define ME_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define ME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/me_pkg.sv
// Shared constants, sequencer state codes and control structs for the
// modular exponentiation block. No dependencies.
package me_pkg;

   localparam int unsigned FIELD_BITS       = 63;
   localparam int unsigned OPERAND_BITS_DEF = 63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_WAIT,
      ST_DONE
   } me_state_type;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MUL,
      OP_SQUARE
   } me_op_type;

   typedef struct packed {
      logic start;
   } me_mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } me_mul_stat_type;

endpackage

>>> design/me_req_if.sv
// Request channel: valid/ready handshake carrying base and exponent.
// Depends on me_pkg for the field width.
interface me_req_if;
   import me_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] base;
   logic [FIELD_BITS-1:0] exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

>>> design/me_rsp_if.sv
// Response channel: valid/ready handshake carrying the power.
// Depends on me_pkg for the field width.
interface me_rsp_if;
   import me_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface

>>> design/me_mulmod.sv
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
// Depends on me_pkg for the command and status structs.
module me_mulmod #(
   parameter int unsigned OPERAND_BITS = me_pkg::OPERAND_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  me_pkg::me_mul_cmd_type     cmd,
   input  logic [OPERAND_BITS-1:0]    x,
   input  logic [OPERAND_BITS-1:0]    y,
   input  logic [OPERAND_BITS-1:0]    m,
   output me_pkg::me_mul_stat_type    stat,
   output logic [OPERAND_BITS-1:0]    product
);
   import me_pkg::*;

   localparam int unsigned W  = OPERAND_BITS;
   localparam int unsigned CW = $clog2(W + 1);
   localparam int unsigned XW = W + 3;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  m_ff, m_in;

   logic [W-1:0]  addend;
   logic [XW-1:0] sum;
   logic [XW-1:0] diff1;
   logic [XW-1:0] diff2;
   logic [W-1:0]  acc_step;

   // 2*acc + x stays below 3m, so one of three parallel candidates is the residue
   always_comb begin
      addend   = y_ff[W-1] ? x_ff : '0;
      sum      = {2'b00, acc_ff, 1'b0} + {3'b000, addend};
      diff1    = sum - {3'b000, m_ff};
      diff2    = sum - {2'b00, m_ff, 1'b0};
      if (!diff2[XW-1]) begin
         acc_step = diff2[W-1:0];
      end else if (!diff1[XW-1]) begin
         acc_step = diff1[W-1:0];
      end else begin
         acc_step = sum[W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (cmd.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
      end else if (busy_ff) begin
         acc_in = acc_step;
         y_in   = {y_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

>>> design/me_ctrl.sv
// Square-and-multiply sequencer: scans the exponent LSB first through a
// shift register and drives the shared bit-serial multiplier. Depends on me_pkg.
module me_ctrl #(
   parameter int unsigned OPERAND_BITS = me_pkg::OPERAND_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [OPERAND_BITS-1:0]    in_base,
   input  logic [OPERAND_BITS-1:0]    in_exponent,
   input  logic [OPERAND_BITS-1:0]    modulus,
   output me_pkg::me_mul_cmd_type     mul_cmd,
   output logic [OPERAND_BITS-1:0]    mul_x,
   output logic [OPERAND_BITS-1:0]    mul_y,
   input  me_pkg::me_mul_stat_type    mul_stat,
   input  logic [OPERAND_BITS-1:0]    mul_product,
   input  logic                       out_free,
   output logic                       fin,
   output logic [OPERAND_BITS-1:0]    result
);
   import me_pkg::*;

   localparam int unsigned W = OPERAND_BITS;

   me_state_type state_ff, state_in;
   me_op_type    op_ff, op_in;
   logic [W-1:0] e_ff, e_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [W-1:0] res_ff, res_in;

   logic e_zero;
   logic e_last;
   logic m_small;

   assign e_zero  = (e_ff == '0);
   assign e_last  = (e_ff[W-1:1] == '0);
   assign m_small = (modulus[W-1:1] == '0);

   // next state and next operation
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (e_zero || m_small) begin
               state_in = ST_DONE;
            end else if (!mul_stat.busy) begin
               state_in = ST_WAIT;
               op_in    = OP_REDUCE;
            end
         end
         ST_STEP: begin
            if (e_zero) begin
               state_in = ST_DONE;
            end else if (!mul_stat.busy) begin
               state_in = ST_WAIT;
               op_in    = e_ff[0] ? OP_MUL : OP_SQUARE;
            end
         end
         ST_WAIT: begin
            if (mul_stat.done) begin
               case (op_ff)
                  OP_REDUCE: state_in = ST_STEP;
                  OP_MUL: begin
                     if (e_last) begin
                        state_in = ST_DONE;
                     end else begin
                        op_in = OP_SQUARE;
                     end
                  end
                  OP_SQUARE: state_in = ST_STEP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      in_ready      = 1'b0;
      mul_cmd.start = 1'b0;
      mul_x         = sq_ff;
      mul_y         = sq_ff;
      fin           = 1'b0;
      case (state_ff)
         ST_IDLE: in_ready = 1'b1;
         ST_CHECK: begin
            // reduce the base as 1 * base mod m
            mul_cmd.start = !e_zero && !m_small && !mul_stat.busy;
            mul_x         = W'(1);
         end
         ST_STEP: begin
            mul_cmd.start = !e_zero && !mul_stat.busy;
            mul_x         = e_ff[0] ? res_ff : sq_ff;
         end
         ST_WAIT: begin
            // chain the square right behind the multiply
            mul_cmd.start = mul_stat.done && (op_ff == OP_MUL) && !e_last;
         end
         ST_DONE: fin = out_free;
         default: in_ready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      e_in   = e_ff;
      sq_in  = sq_ff;
      res_in = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               e_in   = in_exponent;
               sq_in  = in_base;
               res_in = W'(1);
            end
         end
         ST_CHECK: begin
            if (!e_zero && m_small) begin
               res_in = '0;
            end
         end
         ST_WAIT: begin
            if (mul_stat.done) begin
               case (op_ff)
                  OP_REDUCE: sq_in = mul_product;
                  OP_MUL:    res_in = mul_product;
                  OP_SQUARE: begin
                     sq_in = mul_product;
                     e_in  = e_ff >> 1;
                  end
                  default:   sq_in = sq_ff;
               endcase
            end
         end
         default: e_in = e_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_REDUCE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff   <= e_in;
      sq_ff  <= sq_in;
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

>>> design/modular_exponentiation.sv
// A zero exponent or a modulus of 0 or 1 is answered without any modular product;
// otherwise the result takes 1 + (position of top exponent bit) + (set exponent bits)
// modular products, all computed in turn by the one bit-serial multiplier.
// One item in flight; the next is accepted once the result reaches the output register.
// Reset (synchronous, active high) sets the modulus to 1 and empties the pipeline.
module modular_exponentiation #(
   parameter int unsigned OPERAND_BITS = me_pkg::OPERAND_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [me_pkg::FIELD_BITS-1:0] csr_wr_data,
   me_req_if.sink                        req_ch,
   me_rsp_if.source                      rsp_ch
);
   import me_pkg::*;

   localparam int unsigned W = OPERAND_BITS;

   logic [FIELD_BITS-1:0] modulus_ff, modulus_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] power_ff, power_in;

   me_mul_cmd_type  mul_cmd;
   me_mul_stat_type mul_stat;
   logic [W-1:0]    mul_x;
   logic [W-1:0]    mul_y;
   logic [W-1:0]    mul_product;
   logic            out_free;
   logic            fin;
   logic [W-1:0]    result;

   assign modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_valid_in = fin || (rsp_valid_ff && !rsp_ch.ready);
   assign power_in     = fin ? FIELD_BITS'(result) : power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= FIELD_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.power = power_ff;

   me_ctrl #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .in_base     (req_ch.base[W-1:0]),
      .in_exponent (req_ch.exponent[W-1:0]),
      .modulus     (modulus_ff[W-1:0]),
      .mul_cmd     (mul_cmd),
      .mul_x       (mul_x),
      .mul_y       (mul_y),
      .mul_stat    (mul_stat),
      .mul_product (mul_product),
      .out_free    (out_free),
      .fin         (fin),
      .result      (result)
   );

   me_mulmod #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .x       (mul_x),
      .y       (mul_y),
      .m       (modulus_ff[W-1:0]),
      .stat    (mul_stat),
      .product (mul_product)
   );

endmodule

>>> design/me_checker.sv
// Port-level checks for modular_exponentiation, bound to the top level.
// Depends on me_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module me_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [me_pkg::FIELD_BITS-1:0] rsp_power
);
   import me_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   `ME_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `ME_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_power), "power changed while stalled")
   `ME_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")
   `ME_ASSERT_RST(a_one_in_flight, clock, reset, req_fire |=> !req_ready, "second item taken while one in flight")
   `ME_ASSERT_RST(a_no_instant_rsp, clock, reset, req_fire && !rsp_valid |=> !rsp_valid, "response raised the cycle after accept")

endmodule

bind modular_exponentiation me_checker u_me_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_power (rsp_ch.power)
);
